[src/lwed_pkg.sv]
// Shared types and constants for the LWE decryption block.
// Used by the top level, multiplier and divider of the block and by its checker; depends on nothing.
`timescale 1ns / 1ps

package lwed_pkg;

	// Field widths of the item and register formats.
	localparam int VALUE_W   = 64;
	localparam int INDEX_W   = 10;
	localparam int KIND_W    = 2;
	localparam int MSG_W     = 16;
	localparam int PMOD_W    = 17;
	localparam int PROD_W    = 2 * VALUE_W;
	localparam int S_TDATA_W = ((INDEX_W + VALUE_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((MSG_W + 7) / 8) * 8;

	// Key store geometry.
	localparam int KEY_LENGTH = 1024;
	localparam int KEY_AW     = INDEX_W;

	// Bit-serial divider: one quotient bit per cycle over the full product.
	localparam int DIV_STEPS = PROD_W;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	// Register reset values.
	localparam logic [VALUE_W-1:0] CMOD_RESET = 64'd4294967295;
	localparam logic [PMOD_W-1:0]  PMOD_RESET = 17'd256;

	// Configuration register indexes.
	localparam logic REG_CIPHER_MODULUS = 1'b0;
	localparam logic REG_PLAIN_MODULUS  = 1'b1;

	// Item kinds carried on tuser; the fourth code is ignored.
	typedef enum logic [KIND_W-1:0] {
		KIND_KEY  = 2'd0,
		KIND_MASK = 2'd1,
		KIND_BODY = 2'd2
	} kind_t;

endpackage

[src/lwed_ram.sv]
// Single-port-write, registered-read RAM for the secret key elements.
// Generic storage; depends on nothing.
`timescale 1ns / 1ps

module lwed_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [(1 << ADDR_W)];
	logic [DATA_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port with registered data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/lwed_mul.sv]
// Iterative 64 x 64 multiplier built from one 32 x 32 partial-product unit.
// Four partial products are formed in turn and summed into a 128-bit product.
// Depends on lwed_pkg.
`timescale 1ns / 1ps

module lwed_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lwed_pkg::VALUE_W-1:0]  a,
	input  logic [lwed_pkg::VALUE_W-1:0]  b,
	output logic                          done,
	output logic [lwed_pkg::PROD_W-1:0]   prod
);

	localparam int HALF_W = lwed_pkg::VALUE_W / 2;

	logic [lwed_pkg::VALUE_W-1:0] a_q, b_q;
	logic [1:0]                   step_q;
	logic                         run_q;
	logic [lwed_pkg::VALUE_W-1:0] pp_s1;
	logic [1:0]                   sel_s1;
	logic                         pv_s1, last_s1;
	logic [lwed_pkg::PROD_W-1:0]  acc_q;
	logic                         done_q;

	logic [HALF_W-1:0]            a_part, b_part;
	logic [1:0]                   half_sum;
	logic [$clog2(lwed_pkg::PROD_W)-1:0] shamt;

	// Operand halves for the current step: bit 1 picks the half of a, bit 0 of b.
	assign a_part = step_q[1] ? a_q[lwed_pkg::VALUE_W-1:HALF_W] : a_q[HALF_W-1:0];
	assign b_part = step_q[0] ? b_q[lwed_pkg::VALUE_W-1:HALF_W] : b_q[HALF_W-1:0];

	// Weight of the registered partial product in units of one half word.
	assign half_sum = {1'b0, sel_s1[1]} + {1'b0, sel_s1[0]};
	assign shamt    = {half_sum, 5'b0};

	// Control: step counter, partial-product stage and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			step_q  <= '0;
			pv_s1   <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q   <= 1'b1;
				step_q  <= '0;
				pv_s1   <= 1'b0;
				last_s1 <= 1'b0;
			end else begin
				pv_s1   <= run_q;
				last_s1 <= run_q && (step_q == 2'd3);
				if (run_q) begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						run_q <= 1'b0;
					end
				end
				if (pv_s1 && last_s1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: operands, partial product and running sum.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else begin
			if (run_q) begin
				pp_s1  <= {{HALF_W{1'b0}}, a_part} * {{HALF_W{1'b0}}, b_part};
				sel_s1 <= step_q;
			end
			if (pv_s1) begin
				acc_q <= acc_q + ({{lwed_pkg::VALUE_W{1'b0}}, pp_s1} << shamt);
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

[src/lwed_div.sv]
// Bit-serial restoring divider: 128-bit dividend by a 64-bit divisor.
// One quotient bit per cycle; keeps the low 64 quotient bits and the remainder.
// Depends on lwed_pkg.
`timescale 1ns / 1ps

module lwed_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lwed_pkg::PROD_W-1:0]   num,
	input  logic [lwed_pkg::VALUE_W-1:0]  den,
	output logic                          done,
	output logic [lwed_pkg::VALUE_W-1:0]  quo,
	output logic [lwed_pkg::VALUE_W-1:0]  rem
);

	logic [lwed_pkg::PROD_W-1:0]  num_q;
	logic [lwed_pkg::VALUE_W-1:0] den_q, rem_q, quo_q;
	logic [lwed_pkg::DIV_CW-1:0]  cnt_q;
	logic                         run_q, done_q;

	logic [lwed_pkg::VALUE_W:0]   shifted, diff;
	logic                         ge;

	// One step: shift in the next dividend bit, subtract when the divisor fits.
	assign shifted = {rem_q, num_q[lwed_pkg::PROD_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};

	// Control: step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == lwed_pkg::DIV_CW'(lwed_pkg::DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder, quotient and dividend shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[lwed_pkg::PROD_W-2:0], 1'b0};
			rem_q <= ge ? diff[lwed_pkg::VALUE_W-1:0] : shifted[lwed_pkg::VALUE_W-1:0];
			quo_q <= {quo_q[lwed_pkg::VALUE_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

[src/lwe_decrypt.sv]
// LWE decryption block. Key load items (tuser 0) write one secret key element;
// the block is ready again at once. A mask item (tuser 1), unless the ciphertext
// modulus is below 2, multiplies its value by the stored key element at its
// index, reduces the product modulo the ciphertext modulus and adds it into the
// running sum modulo that modulus. A body item (tuser 2) reduces the body and the
// sum, centers their difference, scales it by the plaintext modulus and divides
// with rounding, then clears the sum and sends one message item (zero while
// either modulus is below 2). Both share the single bit-serial divider (two
// reductions per mask item, three per body item) and the four-step 32 x 32
// multiplier. s_axis_tready is low while an item is at work; one finished message
// can wait in the output register while the next item is taken. Key elements are
// undefined until loaded, and a mask item must only name loaded positions. The
// user must see that configuration is written only while the block is idle; the
// block does not enforce it. Depends on lwed_pkg, lwed_ram, lwed_mul and lwed_div.
`timescale 1ns / 1ps

module lwe_decrypt (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input items.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [lwed_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [9:0] index, [73:10] value
	input  logic [lwed_pkg::KIND_W-1:0]     s_axis_tuser,  // [1:0] kind
	// Result items.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [lwed_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // [15:0] message
	// Configuration writes.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [lwed_pkg::VALUE_W-1:0]    cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MASK_RD,
		ST_MASK_MUL,
		ST_MASK_DIV,
		ST_ACC_DIV,
		ST_BODY_BDIV,
		ST_BODY_ADIV,
		ST_BODY_DIFF,
		ST_BODY_WRAP,
		ST_BODY_MAG,
		ST_BODY_MUL,
		ST_BODY_DIV,
		ST_BODY_ROUND,
		ST_BODY_OUT
	} state_t;

	localparam int VW = lwed_pkg::VALUE_W;
	localparam int PW = lwed_pkg::PMOD_W;

	state_t                       state_q;
	logic [VW-1:0]                cmod_q;
	logic [PW-1:0]                pmod_q;
	logic [VW-1:0]                inner_q;
	logic [VW-1:0]                mul_a_q, mul_b_q;
	logic                         mul_start_q, div_start_q;
	logic [lwed_pkg::PROD_W-1:0]  div_num_q;
	logic [VW-1:0]                bmod_q, amod_q, d_q;
	logic                         brw_q, neg_q;
	logic [PW-1:0]                r_q;
	logic                         out_valid_q;
	logic [lwed_pkg::MSG_W-1:0]   out_msg_q;

	logic [lwed_pkg::INDEX_W-1:0] in_index;
	logic [VW-1:0]                in_value;
	logic                         in_acc, key_we, key_re, idx_ok;
	logic [VW-1:0]                key_rdata;
	logic                         mul_done, div_done;
	logic [lwed_pkg::PROD_W-1:0]  mul_prod;
	logic [VW-1:0]                div_quo, div_rem;
	logic [VW:0]                  sum_w, diff_w;
	logic                         round_up, out_free;
	logic [PW-1:0]                msg_w;

	// Input item unpacking and handshakes.
	assign in_index      = s_axis_tdata[lwed_pkg::INDEX_W-1:0];
	assign in_value      = s_axis_tdata[lwed_pkg::INDEX_W +: VW];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign idx_ok        = (32'(in_index) < lwed_pkg::KEY_LENGTH);
	assign key_we        = in_acc && (s_axis_tuser == lwed_pkg::KIND_KEY) && idx_ok;
	assign key_re        = in_acc && (s_axis_tuser == lwed_pkg::KIND_MASK);
	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Datapath helpers around the shared units.
	assign sum_w    = {1'b0, inner_q} + {1'b0, div_rem};
	assign diff_w   = {1'b0, bmod_q} - {1'b0, amod_q};
	assign round_up = (div_rem >= (cmod_q - div_rem));
	assign msg_w    = (neg_q && (r_q != '0)) ? (pmod_q - r_q) : r_q;

	lwed_ram #(
		.ADDR_W (lwed_pkg::KEY_AW),
		.DATA_W (VW)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (in_index),
		.wdata (in_value),
		.re    (key_re),
		.raddr (in_index),
		.rdata (key_rdata)
	);

	lwed_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// Every reduction in the block is by the ciphertext modulus.
	lwed_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num_q),
		.den    (cmod_q),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmod_q <= lwed_pkg::CMOD_RESET;
			pmod_q <= lwed_pkg::PMOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lwed_pkg::REG_CIPHER_MODULUS: cmod_q <= cfg_data;
				lwed_pkg::REG_PLAIN_MODULUS:  pmod_q <= cfg_data[PW-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer with the running sum, unit start pulses and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			inner_q     <= '0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (s_axis_tuser)
							lwed_pkg::KIND_MASK: begin
								mul_a_q <= in_value;
								if ((cmod_q >= VW'(2)) && idx_ok) begin
									state_q <= ST_MASK_RD;
								end
							end
							lwed_pkg::KIND_BODY: begin
								if ((cmod_q < VW'(2)) || (pmod_q < PW'(2))) begin
									r_q     <= '0;
									neg_q   <= 1'b0;
									state_q <= ST_BODY_OUT;
								end else begin
									div_num_q   <= {{VW{1'b0}}, in_value};
									div_start_q <= 1'b1;
									state_q     <= ST_BODY_BDIV;
								end
							end
							default: ;
						endcase
					end
				end
				// Key element is on the RAM output now.
				ST_MASK_RD: begin
					mul_b_q     <= key_rdata;
					mul_start_q <= 1'b1;
					state_q     <= ST_MASK_MUL;
				end
				ST_MASK_MUL: begin
					if (mul_done) begin
						div_num_q   <= mul_prod;
						div_start_q <= 1'b1;
						state_q     <= ST_MASK_DIV;
					end
				end
				// Product residue plus the old sum, reduced once more.
				ST_MASK_DIV: begin
					if (div_done) begin
						div_num_q   <= {{(VW - 1){1'b0}}, sum_w};
						div_start_q <= 1'b1;
						state_q     <= ST_ACC_DIV;
					end
				end
				ST_ACC_DIV: begin
					if (div_done) begin
						inner_q <= div_rem;
						state_q <= ST_IDLE;
					end
				end
				ST_BODY_BDIV: begin
					if (div_done) begin
						bmod_q      <= div_rem;
						div_num_q   <= {{VW{1'b0}}, inner_q};
						div_start_q <= 1'b1;
						state_q     <= ST_BODY_ADIV;
					end
				end
				ST_BODY_ADIV: begin
					if (div_done) begin
						amod_q  <= div_rem;
						state_q <= ST_BODY_DIFF;
					end
				end
				ST_BODY_DIFF: begin
					d_q     <= diff_w[VW-1:0];
					brw_q   <= diff_w[VW];
					state_q <= ST_BODY_WRAP;
				end
				// A borrow means the difference wrapped below zero: add q back.
				ST_BODY_WRAP: begin
					if (brw_q) begin
						d_q <= d_q + cmod_q;
					end
					state_q <= ST_BODY_MAG;
				end
				// Centered reading: values above q/2 stand for negatives.
				ST_BODY_MAG: begin
					neg_q       <= (d_q > (cmod_q >> 1));
					mul_a_q     <= (d_q > (cmod_q >> 1)) ? (cmod_q - d_q) : d_q;
					mul_b_q     <= {{(VW - PW){1'b0}}, pmod_q};
					mul_start_q <= 1'b1;
					state_q     <= ST_BODY_MUL;
				end
				ST_BODY_MUL: begin
					if (mul_done) begin
						div_num_q   <= mul_prod;
						div_start_q <= 1'b1;
						state_q     <= ST_BODY_DIV;
					end
				end
				ST_BODY_DIV: begin
					if (div_done) begin
						state_q <= ST_BODY_ROUND;
					end
				end
				// Round half away from zero. The magnitude is at most q/2, so the
				// rounded value stays below p and needs no further reduction.
				ST_BODY_ROUND: begin
					r_q     <= div_quo[PW-1:0] + PW'(round_up);
					state_q <= ST_BODY_OUT;
				end
				ST_BODY_OUT: begin
					if (out_free) begin
						out_msg_q   <= msg_w[lwed_pkg::MSG_W-1:0];
						out_valid_q <= 1'b1;
						inner_q     <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = lwed_pkg::M_TDATA_W'(out_msg_q);

endmodule

[src/lwed_chk.sv]
// Port-level checker for the LWE decryption block, bound to the top level.
// Depends on lwed_pkg and on the port list of lwe_decrypt.
`timescale 1ns / 1ps

module lwed_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [lwed_pkg::KIND_W-1:0]     s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [lwed_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

	// A result item that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result item withdrawn before it was taken");

	// A stalled result item keeps its message.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result message changed while stalled");

	// The block only goes busy after it has taken an item.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(s_axis_tvalid))
		else $error("input side went busy without an accepted item");

	// A key load never makes the block busy.
	a_key_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == lwed_pkg::KIND_KEY)
		|=> s_axis_tready)
		else $error("key load stalled the input side");

	// A new message appears only as the block returns to idle.
	a_msg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready)
		else $error("message produced while an item is still at work");

endmodule

bind lwe_decrypt lwed_chk u_lwed_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
